/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/ncc_pkg.sv */
// Shared types and constants of the nearest centroid classifier.
package ncc_pkg;

    localparam int NUM_CELLS  = 16;
    localparam int IDX_W      = 4;
    localparam int FEAT_DEPTH = 16;
    localparam int VAL_W      = 16;
    localparam int DIFF_W     = VAL_W + 1;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 38;
    localparam int CNT_W      = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(NUM_CELLS);

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_POINT = 1'b1
    } func_t;

    // One transaction as it travels down the chain of cells, together with
    // the running best match for the point it belongs to.
    typedef struct packed {
        logic                     valid;
        func_t                    func;
        logic [IDX_W-1:0]         cidx;
        logic [IDX_W-1:0]         fidx;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
        logic [IDX_W-1:0]         best_idx;
        logic [DIST_W-1:0]        best_dist;
    } tok_t;

    // Effective number of active centroids: zero acts as one, large values clamp.
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        r = n;
        if (r == '0)
        begin
            r = CNT_W'(1);
        end
        if (r > CNT_MAX)
        begin
            r = CNT_MAX;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ncc_cell.sv */
// One classifier cell: a centroid row, its distance accumulator and two stages.
module ncc_cell
    import ncc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [IDX_W-1:0] cell_id,
    input  logic             active,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic signed [VAL_W-1:0]    row_reg [FEAT_DEPTH];
    logic signed [VAL_W-1:0]    cv;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic [SQ_W-1:0]            sq_next;
    logic [SQ_W-1:0]            sq_reg;
    tok_t                       mid_reg;
    tok_t                       out_reg;
    tok_t                       out_next;
    logic [DIST_W-1:0]          acc_reg;
    logic [DIST_W-1:0]          acc_next;
    logic [DIST_W:0]            sum;
    logic [DIST_W-1:0]          acc_upd;
    logic                       is_point;
    logic                       wr_en;

    // Stage one: fetch the centroid feature and square the difference; a matching load writes the row.
    always_comb
    begin
        cv      = row_reg[tok_in.fidx];
        diff    = DIFF_W'(tok_in.value) - DIFF_W'(cv);
        sq_full = diff * diff;
        sq_next = sq_full[SQ_W-1:0];
        wr_en   = adv && tok_in.valid && (tok_in.func == FUNC_LOAD) &&
                  (tok_in.cidx == cell_id);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_reg[tok_in.fidx] <= tok_in.value;
        end
    end

    // Stage two: saturating accumulate, then fold this cell into the best match.
    always_comb
    begin
        is_point = mid_reg.valid && (mid_reg.func == FUNC_POINT);
        sum      = {1'b0, acc_reg} + (DIST_W+1)'(sq_reg);
        acc_upd  = acc_reg;
        if (is_point && active)
        begin
            acc_upd = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        end
        out_next = mid_reg;
        if (is_point && mid_reg.last && active &&
            ((cell_id == '0) || (acc_upd < mid_reg.best_dist)))
        begin
            out_next.best_idx  = cell_id;
            out_next.best_dist = acc_upd;
        end
        acc_next = (is_point && mid_reg.last) ? '0 : acc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
            sq_reg  <= '0;
            acc_reg <= '0;
        end
        else if (adv)
        begin
            mid_reg <= tok_in;
            sq_reg  <= sq_next;
            out_reg <= out_next;
            acc_reg <= acc_next;
        end
    end

    assign tok_out = out_reg;

endmodule

/* hw/rtl/nearest_centroid_classifier.sv */
// Top level of the nearest centroid classifier: a chain of sixteen cells.
//
//   channel   | handshake                       | payload
//   ----------+---------------------------------+-------------------------------------
//   item      | item_valid / item_ready         | func, centroid_index, feature_index,
//             |                                 | feature_value, last_feature
//   result    | result_valid / result_ready     | nearest_index, min_distance
//   config    | cfg_wr_en (no wait)             | cfg_wr_data (num_clusters)
//
// Every transaction walks the chain through each cell's multiply stage, then its
// accumulate and compare stage; the final result is registered at the output.
// The chain is fully pipelined: one transaction per cycle while it is not frozen.
// Reset clears the chain, the accumulators and the output valid flag and sets
// num_clusters to one; the centroid store and the output payload are not cleared.
// When a finished result reaches the end of the chain while the previous one still
// waits in the output register, the chain freezes and item_ready drops.
module nearest_centroid_classifier
    import ncc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic                    func,
    input  logic [IDX_W-1:0]        centroid_index,
    input  logic [IDX_W-1:0]        feature_index,
    input  logic signed [VAL_W-1:0] feature_value,
    input  logic                    last_feature,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [IDX_W-1:0]        nearest_index,
    output logic [DIST_W-1:0]       min_distance
);

    logic [CNT_W-1:0]  num_clusters_reg;
    logic [CNT_W-1:0]  n_eff;
    logic [NUM_CELLS-1:0] active_vec;
    tok_t              link [NUM_CELLS+1];
    tok_t              tail;
    logic              tail_result;
    logic              adv;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg <= CNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_clusters_reg <= cfg_wr_data;
        end
    end

    assign n_eff = active_count(num_clusters_reg);

    always_comb
    begin
        link[0]           = '0;
        link[0].valid     = item_valid;
        link[0].func      = func_t'(func);
        link[0].cidx      = centroid_index;
        link[0].fidx      = feature_index;
        link[0].value     = feature_value;
        link[0].last      = last_feature;
    end

    genvar c;
    generate
        for (c = 0; c < NUM_CELLS; c++)
        begin : g_cell
            assign active_vec[c] = (CNT_W'(c) < n_eff);

            ncc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .cell_id (IDX_W'(c)),
                .active  (active_vec[c]),
                .tok_in  (link[c]),
                .tok_out (link[c+1])
            );
        end
    endgenerate

    assign tail        = link[NUM_CELLS];
    assign tail_result = tail.valid && (tail.func == FUNC_POINT) && tail.last;

    // The chain only waits when a finished result has nowhere to go.
    assign adv        = !(tail_result && out_valid_reg && !result_ready);
    assign item_ready = adv;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        if (adv && tail_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tail_result)
        begin
            out_idx_reg  <= tail.best_idx;
            out_dist_reg <= tail.best_dist;
        end
    end

    assign result_valid  = out_valid_reg;
    assign nearest_index = out_idx_reg;
    assign min_distance  = out_dist_reg;

endmodule

/* hw/rtl/ncc_checker.sv */
// Port-level checks for the nearest centroid classifier, bound to the top level.
`include "assert_macros.svh"

module ncc_checker
    import ncc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    cfg_wr_en,
    input logic [CNT_W-1:0]        cfg_wr_data,
    input logic                    item_valid,
    input logic                    item_ready,
    input logic                    func,
    input logic [IDX_W-1:0]        centroid_index,
    input logic [IDX_W-1:0]        feature_index,
    input logic signed [VAL_W-1:0] feature_value,
    input logic                    last_feature,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [IDX_W-1:0]        nearest_index,
    input logic [DIST_W-1:0]       min_distance
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_eff;
    logic             in_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            cnt_reg <= cfg_wr_data;
        end
    end

    assign cnt_eff = active_count(cnt_reg);
    assign in_seen = item_valid && (func || !func) && (centroid_index == centroid_index) &&
                     (feature_index == feature_index) && (feature_value == feature_value) &&
                     (last_feature == last_feature);

    // The winner must be one of the active centroids.
    `ASSERT_IMPL(a_idx_active, clk, rst_n, result_valid, ({1'b0, nearest_index} < cnt_eff))

    // Input back-pressure only comes from a result the consumer is not taking.
    `ASSERT_IMPL(a_ready_cause, clk, rst_n, !item_ready, result_valid && !result_ready)

    // A waiting result holds its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, result_valid && !result_ready,
                 result_valid && $stable(nearest_index) && $stable(min_distance))

    // An offered input transaction is always met with ready while the result side is idle.
    `ASSERT_IMPL(a_no_idle_stall, clk, rst_n, in_seen && !result_valid, item_ready)

endmodule

bind nearest_centroid_classifier ncc_checker u_ncc_checker (.*);

/* sim/tb_nearest_centroid_classifier.sv */
// Self-checking testbench for the nearest centroid classifier.
module tb_nearest_centroid_classifier;
    import ncc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 4000;
    localparam logic [63:0] SAT_LIMIT = (64'd1 << DIST_W) - 64'd1;

    typedef struct {
        func_t                   func;
        logic [IDX_W-1:0]        cidx;
        logic [IDX_W-1:0]        fidx;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } item_t;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } match_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    item_valid = 1'b0;
    logic                    item_ready;
    logic                    func = FUNC_LOAD;
    logic [IDX_W-1:0]        centroid_index = '0;
    logic [IDX_W-1:0]        feature_index = '0;
    logic signed [VAL_W-1:0] feature_value = '0;
    logic                    last_feature = 1'b0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic [IDX_W-1:0]        nearest_index;
    logic [DIST_W-1:0]       min_distance;

    // Shadow copy of the block state.
    logic signed [VAL_W-1:0] centroid_mem [NUM_CELLS][FEAT_DEPTH];
    logic [63:0]             dist_acc [NUM_CELLS];
    logic [CNT_W-1:0]        clusters_cfg = CNT_W'(1);
    bit                      written [NUM_CELLS][FEAT_DEPTH];

    item_t  item_q[$];
    match_t nearest_q[$];
    item_t  on_bus;
    match_t want_match;

    int queued_count = 0;
    int load_count = 0;
    int point_count = 0;
    int results_checked = 0;
    int tie_count = 0;
    int sat_count = 0;
    int error_count = 0;
    int cur_active = 1;
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    nearest_centroid_classifier uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .func           (func),
        .centroid_index (centroid_index),
        .feature_index  (feature_index),
        .feature_value  (feature_value),
        .last_feature   (last_feature),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .nearest_index  (nearest_index),
        .min_distance   (min_distance)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // Zero acts as one and anything above the number of cells clamps.
    function automatic int effective_clusters(input logic [CNT_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > NUM_CELLS)
        begin
            return NUM_CELLS;
        end
        return int'(v);
    endfunction

    function automatic void update_distances(input item_t it);
        int n;
        int c;
        int best;
        logic signed [63:0] diff;
        logic [63:0] sum;
        match_t m;
        if (it.func == FUNC_LOAD)
        begin
            centroid_mem[it.cidx][it.fidx] = it.value;
            load_count++;
            return;
        end
        point_count++;
        n = effective_clusters(clusters_cfg);
        for (c = 0; c < n; c++)
        begin
            diff = $signed(it.value) - $signed(centroid_mem[c][it.fidx]);
            sum = dist_acc[c] + 64'(diff * diff);
            dist_acc[c] = (sum > SAT_LIMIT) ? SAT_LIMIT : sum;
        end
        if (!it.last)
        begin
            return;
        end
        best = 0;
        for (c = 1; c < n; c++)
        begin
            if (dist_acc[c] < dist_acc[best])
            begin
                best = c;
            end
        end
        for (c = best + 1; c < n; c++)
        begin
            if (dist_acc[c] == dist_acc[best])
            begin
                tie_count++;
                break;
            end
        end
        if (dist_acc[best] == SAT_LIMIT)
        begin
            sat_count++;
        end
        m.idx = IDX_W'(best);
        m.distance = dist_acc[best][DIST_W-1:0];
        nearest_q.push_back(m);
        for (c = 0; c < NUM_CELLS; c++)
        begin
            dist_acc[c] = '0;
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_feature();
        int t;
        case ($urandom_range(0, 7))
            0: return -VAL_W'(32768);
            1: return VAL_W'(32767);
            2:
            begin
                t = int'($urandom_range(0, 512)) - 256;
                return t[VAL_W-1:0];
            end
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // A few shared values make equal distances, and so ties, likely.
    function automatic logic signed [VAL_W-1:0] rand_centroid();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VAL_W'(256);
            2: return -VAL_W'(256);
            default: return rand_feature();
        endcase
    endfunction

    task automatic push_item(input func_t f, input int c, input int fi,
                             input logic signed [VAL_W-1:0] v, input bit last);
        item_t it;
        it.func = f;
        it.cidx = IDX_W'(c);
        it.fidx = IDX_W'(fi);
        it.value = v;
        it.last = last;
        item_q.push_back(it);
        queued_count++;
    endtask

    task automatic load_centroid(input int c, input int f,
                                 input logic signed [VAL_W-1:0] v);
        push_item(FUNC_LOAD, c, f, v, bit'($urandom_range(0, 1)));
        written[c][f] = 1'b1;
    endtask

    // Mostly a dimension below dims, now and then any dimension that every
    // active centroid already holds.
    function automatic int pick_feature(input int dims);
        int f;
        int c;
        bit ok;
        f = $urandom_range(0, FEAT_DEPTH - 1);
        if ($urandom_range(0, 7) == 0)
        begin
            ok = 1'b1;
            for (c = 0; c < cur_active; c++)
            begin
                if (!written[c][f])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                return f;
            end
        end
        return $urandom_range(0, dims - 1);
    endfunction

    task automatic push_point(input int dims, input int len);
        int i;
        for (i = 0; i < len; i++)
        begin
            push_item(FUNC_POINT, $urandom_range(0, NUM_CELLS - 1), pick_feature(dims),
                      rand_feature(), i == len - 1);
        end
    endtask

    // Waits until the chain has drained, including trailing centroid loads.
    task automatic wait_idle();
        @(negedge clk);
        while (item_q.size() != 0 || item_valid || nearest_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_clusters(input logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        clusters_cfg = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] cfg, input int dims, input int budget,
                             input bit saturate, input bit pressure);
        int start;
        int c;
        int f;
        int len;
        wait_idle();
        write_clusters(cfg);
        cur_active = effective_clusters(cfg);
        start = queued_count;
        for (c = 0; c < cur_active; c++)
        begin
            for (f = 0; f < dims; f++)
            begin
                if (!written[c][f] || $urandom_range(0, 3) == 0)
                begin
                    load_centroid(c, f, rand_centroid());
                end
            end
        end
        if (saturate)
        begin
            // Enough maximal squared differences to pin every active accumulator.
            for (c = 0; c < cur_active; c++)
            begin
                load_centroid(c, 0, -VAL_W'(32768));
            end
            for (f = 0; f < 66; f++)
            begin
                push_item(FUNC_POINT, 0, 0, VAL_W'(32767), f == 65);
            end
        end
        while (queued_count - start < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                load_centroid($urandom_range(0, NUM_CELLS - 1), $urandom_range(0, FEAT_DEPTH - 1),
                              rand_centroid());
            end
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * dims)
                                                   : $urandom_range(1, dims);
                push_point(dims, len);
            end
        end
        if (pressure)
        begin
            hold_req = 1'b1;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                update_distances(on_bus);
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    on_bus = item_q.pop_front();
                    item_valid <= 1'b1;
                    func <= on_bus.func;
                    centroid_index <= on_bus.cidx;
                    feature_index <= on_bus.fidx;
                    feature_value <= on_bus.value;
                    last_feature <= on_bus.last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls on its own changing pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (nearest_q.size() == 0)
                begin
                    report_error($sformatf("unexpected result: index %0d distance %0d",
                                           nearest_index, min_distance));
                end
                else
                begin
                    want_match = nearest_q.pop_front();
                    results_checked++;
                    if (nearest_index !== want_match.idx)
                    begin
                        report_error($sformatf("nearest_index: got %0d expected %0d",
                                               nearest_index, want_match.idx));
                    end
                    if (min_distance !== want_match.distance)
                    begin
                        report_error($sformatf("min_distance: got %0d expected %0d",
                                               min_distance, want_match.distance));
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                // Long hold-off so the chain fills and item_ready drops.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
            begin
                if (rx_left <= 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(16, 96);
                end
                rx_left--;
                case (rx_mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= bit'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_wr_en)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int c = 0; c < NUM_CELLS; c++)
        begin
            dist_acc[c] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Single cluster out of reset: extreme values, first and last dimension,
        // a load marked last, an exact match.
        cur_active = 1;
        push_item(FUNC_LOAD, 0, 0, -VAL_W'(32768), 1'b1);
        written[0][0] = 1'b1;
        load_centroid(0, FEAT_DEPTH - 1, VAL_W'(32767));
        load_centroid(NUM_CELLS - 1, FEAT_DEPTH - 1, -VAL_W'(1));
        push_item(FUNC_POINT, 0, 0, VAL_W'(32767), 1'b0);
        push_item(FUNC_POINT, 0, FEAT_DEPTH - 1, -VAL_W'(32768), 1'b1);
        push_item(FUNC_POINT, NUM_CELLS - 1, 0, -VAL_W'(32768), 1'b1);
        push_item(FUNC_POINT, 0, FEAT_DEPTH - 1, '0, 1'b1);

        // Two clusters: an exact tie, then the second centroid strictly closer.
        wait_idle();
        write_clusters(CNT_W'(2));
        cur_active = 2;
        load_centroid(1, 0, -VAL_W'(32768));
        load_centroid(1, FEAT_DEPTH - 1, VAL_W'(32767));
        push_item(FUNC_POINT, 0, 0, VAL_W'(5), 1'b0);
        push_item(FUNC_POINT, 0, FEAT_DEPTH - 1, VAL_W'(5), 1'b1);
        load_centroid(1, 0, '0);
        push_item(FUNC_POINT, 0, 0, VAL_W'(1), 1'b1);

        // A cluster count of zero compares only the first centroid.
        wait_idle();
        write_clusters('0);
        cur_active = 1;
        push_item(FUNC_POINT, 0, 0, VAL_W'(1), 1'b1);
        push_item(FUNC_POINT, 0, FEAT_DEPTH - 1, VAL_W'(32767), 1'b1);

        run_phase(CNT_W'(16), 2, 70, 1'b0, 1'b0);
        run_phase(CNT_W'(3), 16, 60, 1'b0, 1'b0);
        run_phase(CNT_W'(31), 3, 60, 1'b0, 1'b0);
        run_phase('0, 8, 130, 1'b1, 1'b0);
        run_phase(CNT_W'(17), 1, 110, 1'b0, 1'b1);
        run_phase(CNT_W'(8), 4, 60, 1'b0, 1'b0);
        run_phase(CNT_W'($urandom_range(0, 31)), $urandom_range(1, 6), 60, 1'b0, 1'b0);

        wait_idle();
        $display("Run summary: %0d centroid loads and %0d point features accepted,",
                 load_count, point_count);
        $display("Run summary: %0d results checked, %0d tied, %0d saturated, %0d errors",
                 results_checked, tie_count, sat_count, error_count);
        if (error_count == 0 && nearest_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_cell.sv
hw/rtl/nearest_centroid_classifier.sv
hw/rtl/ncc_checker.sv
sim/tb_nearest_centroid_classifier.sv
